// ===== rtl/lcgbr_pkg.sv =====
// Package for the bounded-range LCG core: constants, FSM states and helpers.
package lcgbr_pkg;

	localparam int unsigned DataW   = 32;
	localparam int unsigned StateW  = 31;
	localparam int unsigned DigitW  = 4;
	localparam int unsigned NumDig  = 8;
	localparam int unsigned DigIdxW = $clog2(NumDig);
	localparam int unsigned BitIdxW = $clog2(StateW);

	localparam logic [DataW-1:0]  LCG_MUL  = 32'h41C6_4E6D;
	localparam logic [StateW-1:0] LCG_INC  = 31'd12345;
	localparam logic [DataW-1:0]  TWO_P31  = 32'h8000_0000;
	localparam logic [DataW-1:0]  SEED_RST = 32'd1;

	localparam logic [DigIdxW-1:0] DIG_LAST = DigIdxW'(NumDig - 1);
	localparam logic [BitIdxW-1:0] BIT_LAST = BitIdxW'(StateW - 1);

	localparam logic [2:0] REG_SEED = 3'd0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_MOD,
		ST_CHECK,
		ST_DONE
	} lcgbr_state_t;

	// multiplier digit, most significant first
	function automatic logic [DigitW-1:0] mul_digit(input logic [DigIdxW-1:0] idx);
		logic [DataW-1:0] sh;
		sh = LCG_MUL >> {~idx, 2'b00};
		return sh[DigitW-1:0];
	endfunction

endpackage

// ===== rtl/lcg_bounded_random_core.sv =====
// Top level of the bounded-range LCG random number core.
// Each request takes one generator step (one 4-bit digit of the LCG multiplier per cycle) and,
// for a span below 2^31, a bit-serial remainder by the span (one bit per cycle) plus a check
// state; a rejected draw repeats the step and the remainder, which happens with probability
// below one half. A request with a span of zero or at least 2^31 takes the generator step only.
// A result waits in an output register, and the next request is taken as soon as the core
// hands its result there.
// The seed register sits at address 0 and loads the generator state (zero loads one).
module lcg_bounded_random_core import lcgbr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [DataW-1:0] pwdata,
	output logic [DataW-1:0] prdata,
	output logic             pready,
	input  logic             req_valid,
	output logic             req_ready,
	input  logic [DataW-1:0] lower_bound,
	input  logic [DataW-1:0] upper_bound,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output logic [DataW-1:0] rnd_value
);

	lcgbr_state_t state_q, state_d;

	logic [DataW-1:0]   seed_q;
	logic [DataW-1:0]   gen_q;
	logic [DataW-1:0]   lo_q;
	logic [DataW-1:0]   span_q;
	logic               wide_q;
	logic [StateW-1:0]  acc_q;
	logic [DigIdxW-1:0] dig_q;
	logic [StateW-1:0]  dvd_q;
	logic [StateW-1:0]  rem_q;
	logic [BitIdxW-1:0] bit_q;
	logic [DataW-1:0]   res_q;
	logic               rsp_valid_q;
	logic [DataW-1:0]   rnd_value_q;

	logic               cfg_wr;
	logic               req_fire;
	logic               mul_last;
	logic               mod_last;
	logic               draw_ok;
	logic               rsp_free;
	logic [DataW-1:0]   span_in;
	logic [StateW+3:0]  part_prod;
	logic [StateW-1:0]  acc_next;
	logic [StateW-1:0]  draw_next;
	logic [DataW-1:0]   trial;
	logic [DataW-1:0]   trial_sub;
	logic [DataW-1:0]   bucket_end;

	assign pready   = 1'b1;
	assign prdata   = seed_q;
	assign cfg_wr   = psel & penable & pwrite & (paddr == REG_SEED);
	assign req_fire = req_valid & req_ready;
	assign rsp_free = ~rsp_valid_q | rsp_ready;

	assign span_in = upper_bound - lower_bound + DataW'(1);

	// Horner step over the multiplier digits, modulo 2^31
	assign part_prod = gen_q[StateW-1:0] * mul_digit(dig_q);
	assign acc_next  = {acc_q[StateW-DigitW-1:0], {DigitW{1'b0}}} + part_prod[StateW-1:0];
	assign draw_next = acc_next + LCG_INC;

	// restoring remainder, one bit per cycle
	assign trial     = {rem_q, dvd_q[StateW-1]};
	assign trial_sub = trial - span_q;

	// draw accepted iff (draw/span + 1) * span <= 2^31
	assign bucket_end = gen_q - {1'b0, rem_q} + span_q;
	assign draw_ok    = bucket_end <= TWO_P31;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (req_fire) state_d = ST_MUL;
			ST_MUL:   if (mul_last) state_d = wide_q ? ST_DONE : ST_MOD;
			ST_MOD:   if (mod_last) state_d = ST_CHECK;
			ST_CHECK: state_d = draw_ok ? ST_DONE : ST_MUL;
			ST_DONE:  if (rsp_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		mul_last  = 1'b0;
		mod_last  = 1'b0;
		unique case (state_q)
			ST_IDLE: req_ready = 1'b1;
			ST_MUL:  mul_last  = (dig_q == DIG_LAST);
			ST_MOD:  mod_last  = (bit_q == BIT_LAST);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seed_q      <= SEED_RST;
			gen_q       <= SEED_RST;
			rsp_valid_q <= 1'b0;
			dig_q       <= '0;
			bit_q       <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				seed_q <= pwdata;
				gen_q  <= (pwdata == '0) ? SEED_RST : pwdata;
			end else if (state_q == ST_MUL && mul_last) begin
				gen_q <= {1'b0, draw_next};
			end
			if (state_q == ST_MUL) dig_q <= dig_q + DigIdxW'(1);
			else                    dig_q <= '0;
			if (state_q == ST_MOD) bit_q <= bit_q + BitIdxW'(1);
			else                    bit_q <= '0;
			if (state_q == ST_DONE && rsp_free) rsp_valid_q <= 1'b1;
			else if (rsp_ready)                 rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			lo_q   <= lower_bound;
			span_q <= span_in;
			wide_q <= (span_in == '0) | span_in[DataW-1];
		end
		unique case (state_q)
			ST_IDLE: acc_q <= '0;
			ST_MUL: begin
				acc_q <= mul_last ? '0 : acc_next;
				rem_q <= '0;
				dvd_q <= draw_next;
				if (mul_last) res_q <= lo_q + {1'b0, draw_next};
			end
			ST_MOD: begin
				dvd_q <= {dvd_q[StateW-2:0], 1'b0};
				if (trial >= span_q) rem_q <= trial_sub[StateW-1:0];
				else                 rem_q <= trial[StateW-1:0];
			end
			ST_CHECK: res_q <= lo_q + {1'b0, rem_q};
			ST_DONE:  if (rsp_free) rnd_value_q <= res_q;
			default: ;
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rnd_value = rnd_value_q;

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the bounded-range LCG core: seeded draws vs. an in-bench predictor.
`timescale 1ns / 1ps

module tb_top;
	import lcgbr_pkg::*;

	localparam logic [31:0] GEN_MULT   = 32'd1103515245;
	localparam logic [31:0] GEN_INC    = 32'd12345;
	localparam logic [31:0] HALF_RANGE = 32'h8000_0000;
	localparam int          HOLD_LEN   = 400;
	localparam int          QUIET_MAX  = 20000;

	typedef struct {
		logic [DataW-1:0] lo;
		logic [DataW-1:0] hi;
	} range_req_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             psel = 1'b0;
	logic             penable = 1'b0;
	logic             pwrite = 1'b0;
	logic [2:0]       paddr = '0;
	logic [DataW-1:0] pwdata = '0;
	logic [DataW-1:0] prdata;
	logic             pready;
	logic             req_valid = 1'b0;
	logic             req_ready;
	logic [DataW-1:0] lower_bound = '0;
	logic [DataW-1:0] upper_bound = '0;
	logic             rsp_valid;
	logic             rsp_ready = 1'b0;
	logic [DataW-1:0] rnd_value;

	range_req_t       request_queue[$];
	logic [DataW-1:0] predicted_draws[$];
	range_req_t       next_req;
	logic [31:0]      lcg_state = 32'd1;
	logic             req_taken = 1'b0;

	int send_idle_pct = 37;
	int recv_idle_pct = 37;
	int hold_trigger = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	int mismatches = 0;
	int n_requests = 0;
	int n_results = 0;
	int n_seeds = 0;
	int n_wide = 0;
	int n_narrow = 0;
	int n_rejected = 0;

	lcg_bounded_random_core u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.lower_bound(lower_bound),
		.upper_bound(upper_bound),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rnd_value  (rnd_value)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic logic [31:0] lcg_advance(input logic [31:0] cur);
		logic [31:0] nxt;
		nxt = cur * GEN_MULT + GEN_INC;
		nxt[31] = 1'b0;
		return nxt;
	endfunction

	// advances the generator state and returns the bounded draw
	function automatic logic [31:0] draw_in_range(input logic [31:0] lo, input logic [31:0] hi);
		logic [31:0] span;
		logic [31:0] limit;
		span = hi - lo + 32'd1;
		if (span == 32'd0 || span >= HALF_RANGE) begin
			n_wide++;
			lcg_state = lcg_advance(lcg_state);
			return lo + lcg_state;
		end
		n_narrow++;
		limit = HALF_RANGE - (HALF_RANGE % span);
		lcg_state = lcg_advance(lcg_state);
		while (lcg_state >= limit) begin
			n_rejected++;
			lcg_state = lcg_advance(lcg_state);
		end
		return lo + (lcg_state % span);
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		mismatches++;
		if (mismatches <= 25)
			$display("MISMATCH %s: got %08h want %08h (result %0d)", what, got, want, n_results);
	endtask

	// driver
	always @(negedge clk) begin
		if (!req_valid || req_taken) begin
			if (arst_n && request_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				next_req = request_queue.pop_front();
				req_valid <= 1'b1;
				lower_bound <= next_req.lo;
				upper_bound <= next_req.hi;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (hold_left != 0) begin
			rsp_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_trigger != hold_seen) begin
			hold_seen <= hold_trigger;
			hold_left <= HOLD_LEN;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		req_taken <= arst_n && req_valid && req_ready;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				predicted_draws.push_back(draw_in_range(lower_bound, upper_bound));
				n_requests++;
			end
			if (rsp_valid && rsp_ready) begin
				n_results++;
				if (predicted_draws.size() == 0)
					report_mismatch("result with no request pending", rnd_value, '0);
				else if (rnd_value !== predicted_draws[0])
					report_mismatch("rnd_value", rnd_value, predicted_draws.pop_front());
				else
					void'(predicted_draws.pop_front());
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable && pready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_MAX) begin
			$display("timeout: no item moved for %0d cycles, %0d results outstanding",
				QUIET_MAX, predicted_draws.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic queue_range(input logic [31:0] lo, input logic [31:0] hi);
		range_req_t r;
		r.lo = lo;
		r.hi = hi;
		request_queue.push_back(r);
	endtask

	task automatic wait_drained();
		do begin
			@(posedge clk);
			#1;
		end while (request_queue.size() != 0 || req_valid || predicted_draws.size() != 0);
	endtask

	task automatic write_seed(input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_SEED;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		lcg_state = (value == 32'd0) ? 32'd1 : value;
		n_seeds++;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic run_random(input int count);
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] span;
		int          sh;
		for (int i = 0; i < count; i++) begin
			lo = $urandom;
			case ($urandom_range(0, 9))
				0, 1, 2: hi = $urandom;
				3, 4: hi = lo + $urandom_range(0, 255);
				5: begin
					sh = $urandom_range(0, 31);
					hi = lo + ((32'd1 << sh) - 32'd1);
				end
				6: begin
					span = $urandom_range(32'h4000_0000, 32'h7FFF_FFFF);
					hi = lo + span - 32'd1;
				end
				7: hi = lo + $urandom_range(32'h7FFF_FFFF, 32'hFFFF_FFFF);
				default: begin
					case ($urandom_range(0, 4))
						0: lo = 32'h0000_0000;
						1: lo = 32'hFFFF_FFFF;
						2: lo = 32'h8000_0000;
						3: lo = 32'h7FFF_FFFF;
						default: ;
					endcase
					case ($urandom_range(0, 4))
						0: hi = 32'h0000_0000;
						1: hi = 32'hFFFF_FFFF;
						2: hi = 32'h8000_0000;
						3: hi = 32'h7FFF_FFFF;
						default: hi = $urandom;
					endcase
				end
			endcase
			queue_range(lo, hi);
		end
		wait_drained();
	endtask

	initial begin
		logic [31:0] inv;
		logic [31:0] zero_seed;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset seed, edge-case bounds
		queue_range(32'h0000_0000, 32'hFFFF_FFFF);
		queue_range(32'h0000_0000, 32'h7FFF_FFFF);
		queue_range(32'h8000_0000, 32'hFFFF_FFFF);
		queue_range(32'h0000_0000, 32'h8000_0000);
		queue_range(32'h7FFF_FFFF, 32'hFFFF_FFFF);
		queue_range(32'h0000_0000, 32'hFFFF_FFFE);
		queue_range(32'h0000_0005, 32'h0000_0005);
		queue_range(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_range(32'h0000_0000, 32'h0000_0001);
		queue_range(32'hFFFF_FFF0, 32'h0000_000F);
		queue_range(32'h0000_000A, 32'h0000_0003);
		queue_range(32'h8000_0000, 32'h7FFF_FFFF);
		queue_range(32'h0000_0001, 32'h0000_0000);
		queue_range(32'hFFFF_FFFF, 32'h0000_0000);
		queue_range(32'h0000_0000, 32'h4000_0000);
		queue_range(32'h4000_0000, 32'h7FFF_FFFE);
		queue_range(32'h1234_5678, 32'h1234_5A5F);
		queue_range(32'h0000_0000, 32'h0000_0002);
		wait_drained();

		write_seed(32'h0000_0000);
		run_random(280);

		// seed with the top bit set whose first advance lands on zero
		inv = GEN_MULT;
		repeat (4) inv = inv * (32'd2 - GEN_MULT * inv);
		zero_seed = ((32'd0 - GEN_INC) * inv) | HALF_RANGE;
		write_seed(zero_seed);
		queue_range(32'h0000_0000, 32'hFFFF_FFFF);
		queue_range(32'h0000_0000, 32'h0000_0006);
		run_random(250);

		// no idling on either side
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_seed(32'hFFFF_FFFF);
		run_random(300);

		// long receiver hold-off while requests keep coming
		recv_idle_pct = 37;
		write_seed($urandom);
		hold_trigger++;
		run_random(300);
		send_idle_pct = 37;

		write_seed(32'h7FFF_FFFF);
		run_random(300);

		write_seed(32'h0000_0001);
		run_random(320);

		repeat (60) @(posedge clk);
		if (predicted_draws.size() != 0)
			report_mismatch("results never returned", predicted_draws.size(), '0);

		$display("Covered %0d requests under %0d seed settings: %0d full/wide spans, %0d narrow",
			n_requests, n_seeds + 1, n_wide, n_narrow);
		$display("Narrow spans rejected %0d draws; %0d results checked, %0d mismatches",
			n_rejected, n_results, mismatches);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
